// ----- rtl/clock_time_setting_controller_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the clock time-setting controller
// Shared implication forms, sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CLOCK_TIME_SETTING_CONTROLLER_UNIT_MACROS_SVH
`define CLOCK_TIME_SETTING_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication.
`define CTSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define CTSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/ctsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Clock time-setting controller package
// Field codes, time record type and the wrap step functions for each field.
// ----------------------------------------------------------------------------
package ctsc_pkg;

  typedef enum logic [2:0] {
    FIELD_HOURS   = 3'd0,
    FIELD_MINUTES = 3'd1,
    FIELD_SECONDS = 3'd2,
    FIELD_DAY     = 3'd3,
    FIELD_MONTH   = 3'd4,
    FIELD_YEAR    = 3'd5
  } field_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } ctsc_time_t;

  localparam logic [7:0] MOD_HOURS  = 8'd24;
  localparam logic [7:0] MOD_MINSEC = 8'd60;
  localparam logic [7:0] MOD_DAY    = 8'd31;
  localparam logic [7:0] MOD_MONTH  = 8'd12;
  localparam logic [7:0] MOD_YEAR   = 8'd100;
  localparam logic [7:0] BACK_HOURS  = 8'd23;
  localparam logic [7:0] BACK_MINSEC = 8'd59;
  localparam logic [7:0] BACK_DAY    = 8'd29;
  localparam logic [7:0] BACK_MONTH  = 8'd10;
  localparam logic [6:0] YEAR_LAST   = 7'd99;

  // Remainder by compare and subtract; valid while x is below three times m.
  function automatic logic [7:0] reduce_mod(input logic [7:0] x, input logic [7:0] m);
    logic [7:0] m2;
    m2 = {m[6:0], 1'b0};
    if (x >= m2) begin
      return x - m2;
    end else if (x >= m) begin
      return x - m;
    end
    return x;
  endfunction

  // One step up with wrap; codes with no field leave the value alone.
  function automatic logic [6:0] field_up(input field_t f, input logic [6:0] v);
    logic [7:0] x;
    logic [7:0] r;
    x = {1'b0, v};
    unique case (f)
      FIELD_HOURS:   r = reduce_mod(x + 8'd1, MOD_HOURS);
      FIELD_MINUTES,
      FIELD_SECONDS: r = reduce_mod(x + 8'd1, MOD_MINSEC);
      FIELD_DAY:     r = 8'd1 + reduce_mod(x, MOD_DAY);
      FIELD_MONTH:   r = 8'd1 + reduce_mod(x, MOD_MONTH);
      FIELD_YEAR:    r = reduce_mod(x + 8'd1, MOD_YEAR);
      default:       r = x;
    endcase
    return r[6:0];
  endfunction

  // One step down with wrap; year zero goes to the last year.
  function automatic logic [6:0] field_dn(input field_t f, input logic [6:0] v);
    logic [7:0] x;
    logic [7:0] r;
    x = {1'b0, v};
    unique case (f)
      FIELD_HOURS:   r = reduce_mod(x + BACK_HOURS, MOD_HOURS);
      FIELD_MINUTES,
      FIELD_SECONDS: r = reduce_mod(x + BACK_MINSEC, MOD_MINSEC);
      FIELD_DAY:     r = 8'd1 + reduce_mod(x + BACK_DAY, MOD_DAY);
      FIELD_MONTH:   r = 8'd1 + reduce_mod(x + BACK_MONTH, MOD_MONTH);
      FIELD_YEAR:    r = (v == 7'd0) ? {1'b0, YEAR_LAST} : reduce_mod(x - 8'd1, MOD_YEAR);
      default:       r = x;
    endcase
    return r[6:0];
  endfunction

endpackage

// ----- rtl/ctsc_if.sv -----
// ----------------------------------------------------------------------------
// Clock time-setting controller channels
// Poll channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface ctsc_poll_if;
  logic       valid;
  logic       ready;
  logic       mode_level;
  logic       plus_level;
  logic       minus_level;
  logic [4:0] chip_hours;
  logic [5:0] chip_minutes;
  logic [5:0] chip_seconds;
  logic [4:0] chip_day;
  logic [3:0] chip_month;
  logic [6:0] chip_year;

  modport source (
    output valid, mode_level, plus_level, minus_level,
    output chip_hours, chip_minutes, chip_seconds, chip_day, chip_month, chip_year,
    input  ready
  );
  modport sink (
    input  valid, mode_level, plus_level, minus_level,
    input  chip_hours, chip_minutes, chip_seconds, chip_day, chip_month, chip_year,
    output ready
  );
endinterface

interface ctsc_result_if;
  logic       valid;
  logic       ready;
  logic [4:0] shown_hours;
  logic [5:0] shown_minutes;
  logic [5:0] shown_seconds;
  logic [4:0] shown_day;
  logic [3:0] shown_month;
  logic [6:0] shown_year;
  logic       commit;
  logic       in_setup;
  logic [2:0] field_index;
  logic       cursor_on;

  modport source (
    output valid, shown_hours, shown_minutes, shown_seconds,
    output shown_day, shown_month, shown_year,
    output commit, in_setup, field_index, cursor_on,
    input  ready
  );
  modport sink (
    input  valid, shown_hours, shown_minutes, shown_seconds,
    input  shown_day, shown_month, shown_year,
    input  commit, in_setup, field_index, cursor_on,
    output ready
  );
endinterface

// ----- rtl/ctsc_edit.sv -----
// ----------------------------------------------------------------------------
// Field editor
// Applies a plus press and then a minus press to the selected held field.
// ----------------------------------------------------------------------------
module ctsc_edit
  import ctsc_pkg::*;
(
  input  field_t     field,
  input  logic       plus_edge,
  input  logic       minus_edge,
  input  ctsc_time_t held,
  output ctsc_time_t held_edit
);

  logic [6:0] sel_val;
  logic [6:0] after_plus;
  logic [6:0] after_minus;

  always_comb begin
    unique case (field)
      FIELD_HOURS:   sel_val = {2'b0, held.hours};
      FIELD_MINUTES: sel_val = {1'b0, held.minutes};
      FIELD_SECONDS: sel_val = {1'b0, held.seconds};
      FIELD_DAY:     sel_val = {2'b0, held.day};
      FIELD_MONTH:   sel_val = {3'b0, held.month};
      FIELD_YEAR:    sel_val = held.year;
      default:       sel_val = 7'd0;
    endcase
  end

  assign after_plus  = plus_edge  ? field_up(field, sel_val)    : sel_val;
  assign after_minus = minus_edge ? field_dn(field, after_plus) : after_plus;

  always_comb begin
    held_edit = held;
    unique case (field)
      FIELD_HOURS:   held_edit.hours   = after_minus[4:0];
      FIELD_MINUTES: held_edit.minutes = after_minus[5:0];
      FIELD_SECONDS: held_edit.seconds = after_minus[5:0];
      FIELD_DAY:     held_edit.day     = after_minus[4:0];
      FIELD_MONTH:   held_edit.month   = after_minus[3:0];
      FIELD_YEAR:    held_edit.year    = after_minus;
      default:       held_edit = held;
    endcase
  end

endmodule

// ----- rtl/clock_time_setting_controller_unit.sv -----
// ----------------------------------------------------------------------------
// Clock time-setting controller
// Tracks the clock chip in normal mode and edits the held time in setup mode.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat carries
//  poll     in         three button levels and one time and date snapshot
//  result   out        held time and date, commit flag, mode, field, cursor
//
// Unless stalled, one poll beat is taken per cycle; its result is registered
// and appears on the next cycle. The rate is one beat per cycle, set by the
// single register stage holding the mode, field, button history and held time.
// A new poll is taken while the result register is empty or is being drained.
// A stalled result holds the result register and the poll side waits.
// rst is synchronous and active high; it clears the mode, field, button
// history, poll counter and result valid, and loads day and month with one.
// ----------------------------------------------------------------------------
module clock_time_setting_controller_unit
  import ctsc_pkg::*;
(
  input logic          clk,
  input logic          rst,
  ctsc_poll_if.sink    poll,
  ctsc_result_if.source result
);

  // Control and held state.
  logic       setup_mode;
  logic       setup_mode_next;
  field_t     selected_field;
  field_t     selected_field_next;
  ctsc_time_t held;
  ctsc_time_t held_next;
  ctsc_time_t held_edit;
  logic       mode_prev;
  logic       plus_prev;
  logic       minus_prev;
  logic [2:0] poll_count;
  logic       commit_next;

  logic       accept;
  logic       mode_edge;
  logic       plus_edge;
  logic       minus_edge;
  ctsc_time_t chip;

  // The result register frees up when empty or when its beat leaves.
  assign poll.ready = !result.valid || result.ready;
  assign accept     = poll.valid && poll.ready;

  // A press is a high-to-low transition between two polls. Plus and minus
  // only count in setup, which is where their history is kept.
  assign mode_edge  = mode_prev && !poll.mode_level;
  assign plus_edge  = setup_mode && plus_prev && !poll.plus_level;
  assign minus_edge = setup_mode && minus_prev && !poll.minus_level;

  assign chip = '{hours:   poll.chip_hours,
                  minutes: poll.chip_minutes,
                  seconds: poll.chip_seconds,
                  day:     poll.chip_day,
                  month:   poll.chip_month,
                  year:    poll.chip_year};

  ctsc_edit u_edit (
    .field      (selected_field),
    .plus_edge  (plus_edge),
    .minus_edge (minus_edge),
    .held       (held),
    .held_edit  (held_edit)
  );

  // Normal mode follows the chip and enters setup on a mode press. In setup
  // a mode press walks through the fields; at the year it commits and leaves.
  always_comb begin
    setup_mode_next     = setup_mode;
    selected_field_next = selected_field;
    commit_next         = 1'b0;
    if (!setup_mode) begin
      held_next = chip;
      if (mode_edge) begin
        setup_mode_next     = 1'b1;
        selected_field_next = FIELD_HOURS;
      end
    end else begin
      held_next = held_edit;
      if (mode_edge) begin
        priority if (selected_field == FIELD_YEAR) begin
          commit_next     = 1'b1;
          setup_mode_next = 1'b0;
        end else if (selected_field < FIELD_YEAR) begin
          selected_field_next = field_t'(selected_field + 3'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_mode     <= 1'b0;
      selected_field <= FIELD_HOURS;
      held           <= '{hours: 5'd0, minutes: 6'd0, seconds: 6'd0,
                          day: 5'd1, month: 4'd1, year: 7'd0};
      mode_prev      <= 1'b0;
      plus_prev      <= 1'b0;
      minus_prev     <= 1'b0;
      poll_count     <= 3'd0;
    end else if (accept) begin
      setup_mode     <= setup_mode_next;
      selected_field <= selected_field_next;
      held           <= held_next;
      mode_prev      <= poll.mode_level;
      if (setup_mode) begin
        plus_prev  <= poll.plus_level;
        minus_prev <= poll.minus_level;
      end
      poll_count <= poll_count + 3'd1;
    end
  end

  // Result register. The mode, field and cursor report the start of the poll.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (poll.ready) begin
      result.valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.shown_hours   <= held_next.hours;
      result.shown_minutes <= held_next.minutes;
      result.shown_seconds <= held_next.seconds;
      result.shown_day     <= held_next.day;
      result.shown_month   <= held_next.month;
      result.shown_year    <= held_next.year;
      result.commit        <= commit_next;
      result.in_setup      <= setup_mode;
      result.field_index   <= selected_field;
      result.cursor_on     <= setup_mode && poll_count[2];
    end
  end

`include "clock_time_setting_controller_unit_macros.svh"

  // A commit only leaves setup from the year field.
  `CTSC_ASSERT_IMP(a_commit_from_year, result.valid && result.commit, result.in_setup && (result.field_index == FIELD_YEAR))
  // After a committing poll the block is back in normal mode.
  `CTSC_ASSERT_NXT(a_commit_leaves_setup, accept && commit_next, !setup_mode)
  // Entering setup from normal mode selects the hours field.
  `CTSC_ASSERT_NXT(a_enter_at_hours, accept && !setup_mode && mode_edge, setup_mode && (selected_field == FIELD_HOURS))
  // The poll counter advances once per accepted beat.
  `CTSC_ASSERT_NXT(a_poll_count_step, accept, poll_count == $past(poll_count) + 3'd1)
  // Button history for plus and minus is frozen outside setup.
  `CTSC_ASSERT_NXT(a_history_frozen, accept && !setup_mode, $stable(plus_prev) && $stable(minus_prev))

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clock time-setting controller testbench
// Drives poll beats into the controller and checks every result beat against
// a predictor kept in step with each accepted poll. The run covers chip
// tracking, a directed walk through every setup field, and random button
// sessions under several idling and backpressure patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import ctsc_pkg::*;

  // The run stops if no beat moves on either channel for this many cycles.
  localparam int WATCHDOG_LIMIT = 5000;

  // One poll beat as the sender sees it.
  typedef struct {
    logic       mode;
    logic       plus;
    logic       minus;
    ctsc_time_t chip;
  } poll_t;

  // One result beat as the predictor expects it.
  typedef struct {
    ctsc_time_t shown;
    logic       commit;
    logic       in_setup;
    field_t     field;
    logic       cursor_on;
  } display_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ctsc_poll_if   poll();
  ctsc_result_if result();

  clock_time_setting_controller_unit dut (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll),
    .result (result)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the controller after reset: normal mode,
  // hours selected, no button history, day and month at one.
  // --------------------------------------------------------------------------
  logic       editing    = 1'b0;
  field_t     edit_field = FIELD_HOURS;
  ctsc_time_t held       = {5'd0, 6'd0, 6'd0, 5'd1, 4'd1, 7'd0};
  logic       mode_was   = 1'b0;
  logic       plus_was   = 1'b0;
  logic       minus_was  = 1'b0;
  logic [2:0] poll_phase = 3'd0;

  // Expected result beats, oldest first.
  display_t pending_displays[$];

  // Knobs shared between the stimulus, the result drain and the watchdog.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // Run statistics and the failure count.
  int errors             = 0;
  int polls_taken        = 0;
  int displays_checked   = 0;
  int setup_polls        = 0;
  int commits_seen       = 0;
  int input_stall_cycles = 0;

  // Steps the selected held field up or down. The wrap arithmetic is applied
  // to whatever value is held, so values loaded out of range from the chip
  // are folded back into range by the first step.
  function automatic void step_held(input bit up);
    int x;
    case (edit_field)
      FIELD_HOURS: begin
        x = int'(held.hours);
        x = up ? (x + 1) % 24 : (x + 23) % 24;
        held.hours = x[4:0];
      end
      FIELD_MINUTES: begin
        x = int'(held.minutes);
        x = up ? (x + 1) % 60 : (x + 59) % 60;
        held.minutes = x[5:0];
      end
      FIELD_SECONDS: begin
        x = int'(held.seconds);
        x = up ? (x + 1) % 60 : (x + 59) % 60;
        held.seconds = x[5:0];
      end
      FIELD_DAY: begin
        x = int'(held.day);
        x = up ? 1 + x % 31 : 1 + (x + 29) % 31;
        held.day = x[4:0];
      end
      FIELD_MONTH: begin
        x = int'(held.month);
        x = up ? 1 + x % 12 : 1 + (x + 10) % 12;
        held.month = x[3:0];
      end
      FIELD_YEAR: begin
        x = int'(held.year);
        // Stepping down from year zero wraps to the last year of the century.
        if (up) begin
          x = (x + 1) % 100;
        end else if (x == 0) begin
          x = 99;
        end else begin
          x = (x - 1) % 100;
        end
        held.year = x[6:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Advances the predictor by one accepted poll and returns the result beat
  // that poll must produce. Mode, field and cursor are reported as they stood
  // at the start of the poll; the held time is reported after the update.
  function automatic display_t next_display(input poll_t p);
    display_t d;
    logic     mode_press;
    logic     plus_press;
    logic     minus_press;
    d.in_setup  = editing;
    d.field     = edit_field;
    d.cursor_on = editing & poll_phase[2];
    d.commit    = 1'b0;
    // A press is a release: high at the last sample, low now. The mode
    // button is sampled on every poll.
    mode_press = mode_was && !p.mode;
    mode_was   = p.mode;
    if (!editing) begin
      // Normal mode follows the chip. Plus and minus are not sampled here, so
      // their history from the last setup session survives.
      held = p.chip;
      if (mode_press) begin
        editing    = 1'b1;
        edit_field = FIELD_HOURS;
      end
    end else begin
      plus_press  = plus_was && !p.plus;
      minus_press = minus_was && !p.minus;
      plus_was    = p.plus;
      minus_was   = p.minus;
      // With both pressed, plus is applied first and minus to its result.
      if (plus_press) begin
        step_held(1'b1);
      end
      if (minus_press) begin
        step_held(1'b0);
      end
      if (mode_press) begin
        if (edit_field == FIELD_YEAR) begin
          d.commit = 1'b1;
          editing  = 1'b0;
        end else begin
          edit_field = field_t'(edit_field + 3'd1);
        end
      end
    end
    poll_phase = poll_phase + 3'd1;
    d.shown    = held;
    return d;
  endfunction

  function automatic poll_t levels(input logic m, input logic pl, input logic mi,
                                   input ctsc_time_t chip);
    poll_t p;
    p.mode  = m;
    p.plus  = pl;
    p.minus = mi;
    p.chip  = chip;
    return p;
  endfunction

  // Mostly sane calendar values; one snapshot in five uses every bit of every
  // field, which puts out-of-range values into the held time.
  function automatic ctsc_time_t random_chip();
    ctsc_time_t  c;
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(4) == 0) begin
      return r[32:0];
    end
    c.hours   = 5'($urandom_range(23));
    c.minutes = 6'($urandom_range(59));
    c.seconds = 6'($urandom_range(59));
    c.day     = 5'($urandom_range(31, 1));
    c.month   = 4'($urandom_range(12, 1));
    c.year    = 7'($urandom_range(99));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Poll sender. Random idle cycles come first, then the beat is offered
  // until it is taken. Acceptance is judged from the values that held just
  // before the edge, and the predictor is advanced at that same edge.
  // --------------------------------------------------------------------------
  task automatic send_poll(input poll_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      poll.valid <= 1'b0;
      @(posedge clk);
    end
    poll.valid        <= 1'b1;
    poll.mode_level   <= p.mode;
    poll.plus_level   <= p.plus;
    poll.minus_level  <= p.minus;
    poll.chip_hours   <= p.chip.hours;
    poll.chip_minutes <= p.chip.minutes;
    poll.chip_seconds <= p.chip.seconds;
    poll.chip_day     <= p.chip.day;
    poll.chip_month   <= p.chip.month;
    poll.chip_year    <= p.chip.year;
    @(posedge clk);
    while (!poll.ready) begin
      @(posedge clk);
    end
    pending_displays.push_back(next_display(p));
    polls_taken++;
  endtask

  // The sender goes quiet until every expected result beat has come back.
  // The loop waits for an edge before it checks, so the valid drop never shares
  // a time step with the next beat's valid.
  task automatic drain_displays();
    poll.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_displays.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Result drain. Ready stalls at the current rate, except while a long
  // hold-off requested by a test is counting down here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [6:0] want,
                             input logic [6:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Every accepted result beat is compared with the oldest expectation.
  always @(posedge clk) begin : display_check
    display_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_displays.size() == 0) begin
        errors++;
        $display("%0t: result beat with no poll outstanding, expected none, actual hours %0d",
                 $time, result.shown_hours);
      end else begin
        want = pending_displays.pop_front();
        displays_checked++;
        if (want.in_setup) begin
          setup_polls++;
        end
        if (want.commit) begin
          commits_seen++;
        end
        check_field("shown_hours",   7'(want.shown.hours),   7'(result.shown_hours));
        check_field("shown_minutes", 7'(want.shown.minutes), 7'(result.shown_minutes));
        check_field("shown_seconds", 7'(want.shown.seconds), 7'(result.shown_seconds));
        check_field("shown_day",     7'(want.shown.day),     7'(result.shown_day));
        check_field("shown_month",   7'(want.shown.month),   7'(result.shown_month));
        check_field("shown_year",    want.shown.year,        result.shown_year);
        check_field("commit",        7'(want.commit),        7'(result.commit));
        check_field("in_setup",      7'(want.in_setup),      7'(result.in_setup));
        check_field("field_index",   7'(want.field),         7'(result.field_index));
        check_field("cursor_on",     7'(want.cursor_on),     7'(result.cursor_on));
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on either channel. It also
  // tallies the cycles in which the poll side is held off.
  always @(posedge clk) begin
    if (rst || (poll.valid && poll.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (!rst && poll.valid && !poll.ready) begin
      input_stall_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results outstanding.",
               quiet_cycles, pending_displays.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Normal mode copies the chip snapshot straight through, all-zero and
  // all-ones alike. Plus and minus levels are ignored here. The first beat
  // also shows the reset mode, field and cursor.
  task automatic test_chip_tracking();
    send_poll(levels(1'b0, 1'b1, 1'b1, '0));
    send_poll(levels(1'b0, 1'b0, 1'b0, '1));
  endtask

  // Enters setup with a snapshot that holds out-of-range values and zeros,
  // then walks every field. Hours get plus and minus together; the other
  // fields alternate minus and plus, so minutes, day and year wrap downward
  // from zero and seconds and month fold in from beyond their range. The
  // release at year commits and at the same time arms plus for the next test.
  task automatic test_field_walk();
    ctsc_time_t odd_chip;
    odd_chip = {5'd31, 6'd0, 6'd63, 5'd0, 4'd15, 7'd0};
    send_poll(levels(1'b1, 1'b0, 1'b0, odd_chip));
    send_poll(levels(1'b0, 1'b0, 1'b0, odd_chip));
    send_poll(levels(1'b1, 1'b1, 1'b1, random_chip()));
    send_poll(levels(1'b0, 1'b0, 1'b0, random_chip()));
    send_poll(levels(1'b1, 1'b0, 1'b1, random_chip()));
    send_poll(levels(1'b0, 1'b0, 1'b0, random_chip()));
    send_poll(levels(1'b1, 1'b1, 1'b0, random_chip()));
    send_poll(levels(1'b0, 1'b0, 1'b0, random_chip()));
    send_poll(levels(1'b1, 1'b0, 1'b1, random_chip()));
    send_poll(levels(1'b0, 1'b0, 1'b0, random_chip()));
    send_poll(levels(1'b1, 1'b1, 1'b0, random_chip()));
    send_poll(levels(1'b0, 1'b0, 1'b0, random_chip()));
    send_poll(levels(1'b1, 1'b0, 1'b1, random_chip()));
    send_poll(levels(1'b0, 1'b1, 1'b0, random_chip()));
  endtask

  // Plus was left high when setup ended. Normal mode does not sample it, so
  // the first setup poll with plus low must count as a press on hours.
  task automatic test_stale_press();
    send_poll(levels(1'b1, 1'b0, 1'b0, random_chip()));
    send_poll(levels(1'b0, 1'b0, 1'b0, random_chip()));
    send_poll(levels(1'b0, 1'b0, 1'b0, random_chip()));
  endtask

  // Random button sessions. Mode is held more often in setup than in normal
  // mode, so most sessions run through all six fields to a commit, while
  // plus and minus toggle freely in both modes.
  task automatic test_random_sessions(input int count);
    for (int i = 0; i < count; i++) begin
      send_poll(levels($urandom_range(99) < (editing ? 30 : 15),
                       $urandom_range(99) < 50,
                       $urandom_range(99) < 45,
                       random_chip()));
    end
  endtask

  // The result side holds off for a long stretch while polls keep coming, so
  // the result register fills and the poll side stalls. The sender then
  // waits for every outstanding result.
  task automatic test_backpressure();
    hold_request = 80;
    for (int i = 0; i < 8; i++) begin
      send_poll(levels(1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), random_chip()));
    end
    drain_displays();
  endtask

  initial begin
    poll.valid        = 1'b0;
    poll.mode_level   = 1'b0;
    poll.plus_level   = 1'b0;
    poll.minus_level  = 1'b0;
    poll.chip_hours   = '0;
    poll.chip_minutes = '0;
    poll.chip_seconds = '0;
    poll.chip_day     = '0;
    poll.chip_month   = '0;
    poll.chip_year    = '0;
    result.ready      = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with no idling on either side.
    test_chip_tracking();
    test_field_walk();
    test_stale_press();
    drain_displays();

    // Random part, one phase per idling pattern.
    test_random_sessions(150);
    test_backpressure();

    send_idle_pct = 81;
    stall_pct     = 0;
    test_random_sessions(150);
    drain_displays();

    send_idle_pct = 0;
    stall_pct     = 81;
    test_random_sessions(150);
    drain_displays();

    send_idle_pct = 30;
    stall_pct     = 30;
    test_random_sessions(150);

    // Wind down: let every result arrive, then keep watching for stray beats.
    drain_displays();
    repeat (10) @(posedge clk);
    if (pending_displays.size() != 0) begin
      errors++;
      $display("%0t: results outstanding at end, expected 0, actual %0d",
               $time, pending_displays.size());
    end

    $display("Covered %0d polls and %0d checked results, %0d of them in setup, %0d commits.",
             polls_taken, displays_checked, setup_polls, commits_seen);
    $display("Poll side was held off for %0d cycles; %0d mismatches.",
             input_stall_cycles, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
